// ===== hdl/hpest_pkg.sv =====
// Shared types, constants and helper functions for the hover/press slot table.
`timescale 1ns / 1ps

package hpest_pkg;

   localparam logic [15:0]        LEVEL_ONE = 16'h8000;
   localparam logic signed [16:0] MATCH_TOL = 17'sd8;

   typedef enum logic [2:0] {
      CSR_FRAME_TIME  = 3'd0,
      CSR_MOTION_ON   = 3'd1,
      CSR_HOVER_UP    = 3'd2,
      CSR_HOVER_DOWN  = 3'd3,
      CSR_PRESS_UP    = 3'd4,
      CSR_PRESS_DOWN  = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic signed [15:0] h;
      logic signed [15:0] w;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } box_type;

   typedef struct packed {
      box_type     box;
      logic [15:0] hover;
      logic [15:0] press;
      logic [31:0] hover_time;
      logic        hover_mark;
      logic        hold_mark;
      logic        press_armed;
   } slot_type;

   typedef struct packed {
      logic               func;
      box_type            box;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic               held;
      logic               went;
   } query_type;

   function automatic logic coord_near(input logic signed [15:0] a,
                                       input logic signed [15:0] b);
      logic signed [16:0] d;
      d = {a[15], a} - {b[15], b};
      return (d > -MATCH_TOL) && (d < MATCH_TOL);
   endfunction

   function automatic logic box_match(input box_type a, input box_type b);
      return coord_near(a.x, b.x) && coord_near(a.y, b.y) &&
             coord_near(a.w, b.w) && coord_near(a.h, b.h);
   endfunction

   function automatic logic [15:0] ease_level(input logic [15:0] v,
                                              input logic        up,
                                              input logic        motion,
                                              input logic [15:0] rise,
                                              input logic [15:0] fall);
      logic [16:0] sum;
      logic [15:0] res;
      sum = {1'b0, v} + {1'b0, rise};
      if (!motion) begin
         res = up ? LEVEL_ONE : 16'd0;
      end else if (up) begin
         res = (sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : sum[15:0];
      end else begin
         res = (fall >= v) ? 16'd0 : (v - fall);
      end
      return res;
   endfunction

endpackage

// ===== hdl/hover_press_ease_slot_table.sv =====
// Hover/press slot table: rectangle tracking, eviction, per-frame easing and CSRs.
`timescale 1ns / 1ps

// A table of SLOTS entries tracks control rectangles that match within seven
// units per coordinate. A query word (func 1) finds or allocates the entry of
// its rectangle when the pointer is inside, marks hover, hold and press, and
// returns one result word with hover level, press level and hover time; a
// pointer outside only looks the entry up. A tick word (func 0) eases every
// live entry, accumulates hover time, frees faded entries and returns no
// word. One slot is visited per cycle through a single slot read port and a
// shared match/ease unit: a query runs an inside test, a scan of all slots
// and an update that loads the result register, and waits in the update only
// while a previous result is still stalled; a tick visits every slot once.
// req_stall is high for the whole time a word is in work. The CSRs must be
// written only while the block is idle; the block does not enforce this.
module hover_press_ease_slot_table
   import hpest_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic signed [15:0] req_box_x,
   input  logic signed [15:0] req_box_y,
   input  logic signed [15:0] req_box_w,
   input  logic signed [15:0] req_box_h,
   input  logic signed [15:0] req_pointer_x,
   input  logic signed [15:0] req_pointer_y,
   input  logic               req_button_held,
   input  logic               req_button_went_down,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_hover_level,
   output logic [15:0]        rsp_press_level,
   output logic [31:0]        rsp_hover_time,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_APPLY,
      ST_TICK
   } state_type;

   logic [15:0] frame_time_ff;
   logic        motion_on_ff;
   logic [15:0] hover_up_ff;
   logic [15:0] hover_down_ff;
   logic [15:0] press_up_ff;
   logic [15:0] press_down_ff;
   logic        csr_wr;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   query_type        q_ff, q_in;
   logic             inside_ff, inside_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [15:0]      best_lvl_ff, best_lvl_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_hover_ff, rsp_hover_in;
   logic [15:0]      rsp_press_ff, rsp_press_in;
   logic [31:0]      rsp_time_ff, rsp_time_in;

   logic [SLOTS-1:0] valid_ff;
   slot_type         entry_ff [SLOTS];

   logic [IDX_W-1:0] apply_idx;
   logic [IDX_W-1:0] rd_idx;
   slot_type         rd_entry;
   logic [15:0]      rd_lvl;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   slot_type         wr_entry;
   logic             wr_valid;

   logic signed [16:0] x_end;
   logic signed [16:0] y_end;
   logic [32:0]        time_sum;
   slot_type           upd;
   logic               dipped;

   // CSR port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff <= '0;
         motion_on_ff  <= 1'b1;
         hover_up_ff   <= '0;
         hover_down_ff <= '0;
         press_up_ff   <= '0;
         press_down_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx_type'(paddr[4:2]))
            CSR_FRAME_TIME: frame_time_ff <= pwdata[15:0];
            CSR_MOTION_ON:  motion_on_ff  <= pwdata[0];
            CSR_HOVER_UP:   hover_up_ff   <= pwdata[15:0];
            CSR_HOVER_DOWN: hover_down_ff <= pwdata[15:0];
            CSR_PRESS_UP:   press_up_ff   <= pwdata[15:0];
            CSR_PRESS_DOWN: press_down_ff <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx_type'(paddr[4:2]))
         CSR_FRAME_TIME: prdata = {16'd0, frame_time_ff};
         CSR_MOTION_ON:  prdata = {31'd0, motion_on_ff};
         CSR_HOVER_UP:   prdata = {16'd0, hover_up_ff};
         CSR_HOVER_DOWN: prdata = {16'd0, hover_down_ff};
         CSR_PRESS_UP:   prdata = {16'd0, press_up_ff};
         CSR_PRESS_DOWN: prdata = {16'd0, press_down_ff};
         default:        prdata = '0;
      endcase
   end

   // Slot read port
   assign apply_idx = found_ff ? match_idx_ff : (free_found_ff ? free_idx_ff : best_idx_ff);
   assign rd_idx    = (state_ff == ST_APPLY) ? apply_idx : scan_idx_ff;
   assign rd_entry  = entry_ff[rd_idx];
   assign rd_lvl    = (rd_entry.hover > rd_entry.press) ? rd_entry.hover : rd_entry.press;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hover_level = rsp_hover_ff;
   assign rsp_press_level = rsp_press_ff;
   assign rsp_hover_time  = rsp_time_ff;

   assign x_end    = {q_ff.box.x[15], q_ff.box.x} + {q_ff.box.w[15], q_ff.box.w};
   assign y_end    = {q_ff.box.y[15], q_ff.box.y} + {q_ff.box.h[15], q_ff.box.h};
   assign time_sum = {1'b0, rd_entry.hover_time} + {17'd0, frame_time_ff};
   assign dipped   = rd_entry.press_armed && rd_entry.hold_mark && rd_entry.hover_mark;

   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      q_in          = q_ff;
      inside_in     = inside_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_idx_in   = best_idx_ff;
      best_lvl_in   = best_lvl_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hover_in  = rsp_hover_ff;
      rsp_press_in  = rsp_press_ff;
      rsp_time_in   = rsp_time_ff;
      wr_en         = 1'b0;
      wr_idx        = scan_idx_ff;
      wr_valid      = 1'b1;
      upd           = rd_entry;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               q_in.func   = req_func;
               q_in.box.x  = req_box_x;
               q_in.box.y  = req_box_y;
               q_in.box.w  = req_box_w;
               q_in.box.h  = req_box_h;
               q_in.px     = req_pointer_x;
               q_in.py     = req_pointer_y;
               q_in.held   = req_button_held;
               q_in.went   = req_button_went_down;
               scan_idx_in = '0;
               state_in    = req_func ? ST_CHECK : ST_TICK;
            end
         end
         ST_CHECK: begin
            inside_in = (q_ff.px >= q_ff.box.x) &&
                        ($signed({q_ff.px[15], q_ff.px}) < x_end) &&
                        (q_ff.py >= q_ff.box.y) &&
                        ($signed({q_ff.py[15], q_ff.py}) < y_end);
            found_in      = 1'b0;
            free_found_in = 1'b0;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (valid_ff[scan_idx_ff] && !found_ff && box_match(rd_entry.box, q_ff.box)) begin
               found_in     = 1'b1;
               match_idx_in = scan_idx_ff;
            end
            if (!valid_ff[scan_idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = scan_idx_ff;
            end
            if ((scan_idx_ff == '0) || (rd_lvl < best_lvl_ff)) begin
               best_idx_in = scan_idx_ff;
               best_lvl_in = rd_lvl;
            end
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_APPLY;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_APPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (inside_ff) begin
                  if (!found_ff) begin
                     upd     = '0;
                     upd.box = q_ff.box;
                  end
                  upd.hover_mark = 1'b1;
                  upd.hold_mark  = upd.hold_mark | q_ff.held;
                  if (q_ff.went) begin
                     upd.press_armed = 1'b1;
                     upd.press       = '0;
                  end
                  if (!motion_on_ff) begin
                     upd.hover = LEVEL_ONE;
                     upd.press = (upd.press_armed && q_ff.held) ? LEVEL_ONE : 16'd0;
                  end
                  wr_en        = 1'b1;
                  wr_idx       = apply_idx;
                  rsp_hover_in = upd.hover;
                  rsp_press_in = upd.press;
                  rsp_time_in  = upd.hover_time;
               end else if (motion_on_ff && found_ff) begin
                  rsp_hover_in = rd_entry.hover;
                  rsp_press_in = rd_entry.press;
                  rsp_time_in  = '0;
               end else begin
                  rsp_hover_in = '0;
                  rsp_press_in = '0;
                  rsp_time_in  = '0;
               end
            end
         end
         ST_TICK: begin
            upd.hover = ease_level(rd_entry.hover, rd_entry.hover_mark, motion_on_ff,
                                   hover_up_ff, hover_down_ff);
            if (rd_entry.hover_mark) begin
               upd.hover_time = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
            end else begin
               upd.hover_time = '0;
            end
            upd.press = ease_level(rd_entry.press, dipped, motion_on_ff,
                                   press_up_ff, press_down_ff);
            upd.press_armed = rd_entry.press_armed && rd_entry.hold_mark;
            upd.hover_mark  = 1'b0;
            upd.hold_mark   = 1'b0;
            wr_en    = valid_ff[scan_idx_ff];
            wr_valid = rd_entry.hover_mark || (upd.hover != '0) || (upd.press != '0);
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign wr_entry = upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff   <= scan_idx_in;
      q_ff          <= q_in;
      inside_ff     <= inside_in;
      found_ff      <= found_in;
      match_idx_ff  <= match_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_lvl_ff   <= best_lvl_in;
      rsp_hover_ff  <= rsp_hover_in;
      rsp_press_ff  <= rsp_press_in;
      rsp_time_ff   <= rsp_time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= wr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_idx] <= wr_entry;
      end
   end

`ifndef ASSERT_OFF
   a_result_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_APPLY))
      else $error("result word raised outside the update step");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (wr_en && wr_valid) |=> valid_ff[$past(wr_idx)])
      else $error("written slot not marked live");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> (state_ff == ST_SCAN || state_ff == ST_APPLY))
      else $error("scan left without update");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word accepted while busy");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the hover/press slot table: directed and random words against a predictor.
`timescale 1ns / 1ps

module testbench;
   import hpest_pkg::*;

   localparam int SLOTS       = 8;
   localparam int FULL        = 32768;
   localparam int POOL        = 12;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [15:0] hover;
      logic [15:0] press;
      logic [31:0] hover_time;
   } levels_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_func = 1'b0;
   logic signed [15:0] req_box_x = '0;
   logic signed [15:0] req_box_y = '0;
   logic signed [15:0] req_box_w = '0;
   logic signed [15:0] req_box_h = '0;
   logic signed [15:0] req_pointer_x = '0;
   logic signed [15:0] req_pointer_y = '0;
   logic               req_button_held = 1'b0;
   logic               req_button_went_down = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_hover_level;
   logic [15:0]        rsp_press_level;
   logic [31:0]        rsp_hover_time;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int fail_count   = 0;
   int cycle_count  = 0;

   levels_type levels_due[$];

   logic [15:0] frame_time_q;
   logic        motion_q;
   logic [15:0] hover_up_q;
   logic [15:0] hover_down_q;
   logic [15:0] press_up_q;
   logic [15:0] press_down_q;

   bit          slot_live    [SLOTS];
   box_type     slot_box     [SLOTS];
   logic [15:0] slot_hover   [SLOTS];
   logic [15:0] slot_press   [SLOTS];
   logic [31:0] slot_time    [SLOTS];
   bit          slot_hovered [SLOTS];
   bit          slot_held    [SLOTS];
   bit          slot_pressed [SLOTS];

   box_type box_pool[POOL];

   hover_press_ease_slot_table #(
      .SLOTS(SLOTS)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_box_x            (req_box_x),
      .req_box_y            (req_box_y),
      .req_box_w            (req_box_w),
      .req_box_h            (req_box_h),
      .req_pointer_x        (req_pointer_x),
      .req_pointer_y        (req_pointer_y),
      .req_button_held      (req_button_held),
      .req_button_went_down (req_button_went_down),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_hover_level      (rsp_hover_level),
      .rsp_press_level      (rsp_press_level),
      .rsp_hover_time       (rsp_hover_time),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic bit coord_close(input logic signed [15:0] a,
                                      input logic signed [15:0] b);
      int d;
      d = int'(a) - int'(b);
      return (d > -8) && (d < 8);
   endfunction

   function automatic bit boxes_close(input box_type a, input box_type b);
      return coord_close(a.x, b.x) && coord_close(a.y, b.y) &&
             coord_close(a.w, b.w) && coord_close(a.h, b.h);
   endfunction

   function automatic int lookup_slot(input box_type b);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i] && boxes_close(slot_box[i], b)) return i;
      end
      return -1;
   endfunction

   function automatic int level_peak(input int i);
      return (slot_hover[i] > slot_press[i]) ? int'(slot_hover[i]) : int'(slot_press[i]);
   endfunction

   function automatic logic [15:0] eased(input logic [15:0] v, input bit up,
                                         input logic [15:0] rise,
                                         input logic [15:0] fall);
      int r;
      if (!motion_q) return up ? LEVEL_ONE : 16'd0;
      r = up ? int'(v) + int'(rise) : int'(v) - int'(fall);
      if (r < 0) r = 0;
      if (r > FULL) r = FULL;
      return r[15:0];
   endfunction

   task automatic clear_predictor();
      frame_time_q = '0;
      motion_q     = 1'b1;
      hover_up_q   = '0;
      hover_down_q = '0;
      press_up_q   = '0;
      press_down_q = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_live[i]    = 1'b0;
         slot_box[i]     = '0;
         slot_hover[i]   = '0;
         slot_press[i]   = '0;
         slot_time[i]    = '0;
         slot_hovered[i] = 1'b0;
         slot_held[i]    = 1'b0;
         slot_pressed[i] = 1'b0;
      end
   endtask

   task automatic apply_tick();
      logic [32:0] t;
      bit          dipped;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i]) begin
            slot_hover[i] = eased(slot_hover[i], slot_hovered[i], hover_up_q, hover_down_q);
            if (slot_hovered[i]) begin
               t = {1'b0, slot_time[i]} + {17'd0, frame_time_q};
               slot_time[i] = t[32] ? 32'hFFFF_FFFF : t[31:0];
            end else begin
               slot_time[i] = '0;
            end
            dipped = slot_pressed[i] && slot_held[i] && slot_hovered[i];
            slot_press[i] = eased(slot_press[i], dipped, press_up_q, press_down_q);
            if (!slot_held[i]) slot_pressed[i] = 1'b0;
            if (!slot_hovered[i] && slot_hover[i] == 0 && slot_press[i] == 0)
               slot_live[i] = 1'b0;
            slot_hovered[i] = 1'b0;
            slot_held[i]    = 1'b0;
         end
      end
   endtask

   task automatic apply_query(input query_type w);
      int         bx, by, bw, bh, px, py, slot, best;
      levels_type word;
      bx = $signed(w.box.x);
      by = $signed(w.box.y);
      bw = $signed(w.box.w);
      bh = $signed(w.box.h);
      px = $signed(w.px);
      py = $signed(w.py);
      word = '0;
      if (!(px >= bx && px < bx + bw && py >= by && py < by + bh)) begin
         if (motion_q) begin
            slot = lookup_slot(w.box);
            if (slot >= 0) begin
               word.hover = slot_hover[slot];
               word.press = slot_press[slot];
            end
         end
      end else begin
         slot = lookup_slot(w.box);
         if (slot < 0) begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!slot_live[i]) slot = i;
            end
            if (slot < 0) begin
               best = 0;
               for (int i = 1; i < SLOTS; i++) begin
                  if (level_peak(i) < level_peak(best)) best = i;
               end
               slot = best;
            end
            slot_live[slot]    = 1'b1;
            slot_box[slot]     = w.box;
            slot_hover[slot]   = '0;
            slot_press[slot]   = '0;
            slot_time[slot]    = '0;
            slot_hovered[slot] = 1'b0;
            slot_held[slot]    = 1'b0;
            slot_pressed[slot] = 1'b0;
         end
         slot_hovered[slot] = 1'b1;
         if (w.held) slot_held[slot] = 1'b1;
         if (w.went) begin
            slot_pressed[slot] = 1'b1;
            slot_press[slot]   = '0;
         end
         if (!motion_q) begin
            slot_hover[slot] = LEVEL_ONE;
            slot_press[slot] = (slot_pressed[slot] && w.held) ? LEVEL_ONE : 16'd0;
         end
         word = {slot_hover[slot], slot_press[slot], slot_time[slot]};
      end
      levels_due.push_back(word);
   endtask

   // ---------------------------------------------------------------- words

   function automatic box_type make_box(input int x, input int y, input int w, input int h);
      box_type b;
      b.x = x[15:0];
      b.y = y[15:0];
      b.w = w[15:0];
      b.h = h[15:0];
      return b;
   endfunction

   function automatic query_type make_query(input box_type b, input int px, input int py,
                                            input bit held, input bit went);
      query_type w;
      w.func = 1'b1;
      w.box  = b;
      w.px   = px[15:0];
      w.py   = py[15:0];
      w.held = held;
      w.went = went;
      return w;
   endfunction

   function automatic query_type tick_word();
      logic [127:0] raw;
      query_type    w;
      raw = {$urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(query_type)-1:0];
      w.func = 1'b0;
      return w;
   endfunction

   function automatic query_type random_query();
      box_type b;
      int      bx, by, bw, bh, px, py;
      b  = box_pool[$urandom_range(0, POOL - 1)];
      bx = $signed(b.x);
      by = $signed(b.y);
      bw = $signed(b.w);
      bh = $signed(b.h);
      // nudge around the match tolerance on both sides
      if ($urandom_range(0, 3) == 0) begin
         bx += int'($urandom_range(0, 16)) - 8;
         by += int'($urandom_range(0, 16)) - 8;
         bw += int'($urandom_range(0, 16)) - 8;
         bh += int'($urandom_range(0, 16)) - 8;
      end
      if ($urandom_range(0, 99) < 80 && bw > 0 && bh > 0) begin
         px = bx + int'($urandom_range(0, bw - 1));
         py = by + int'($urandom_range(0, bh - 1));
      end else begin
         px = $urandom_range(0, 1) ? bx - 1 - int'($urandom_range(0, 31))
                                   : bx + bw + int'($urandom_range(0, 31));
         py = by + int'($urandom_range(0, 63));
      end
      return make_query(make_box(bx, by, bw, bh), px, py,
                        1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
   endfunction

   task automatic fill_pool();
      for (int k = 0; k < POOL; k++) begin
         box_pool[k] = make_box(int'($urandom_range(0, 32000)) - 16000,
                                int'($urandom_range(0, 32000)) - 16000,
                                $urandom_range(16, 1600), $urandom_range(16, 1600));
      end
      box_pool[POOL - 2].w = '0;
      box_pool[POOL - 1].h = -16'sd48;
   endtask

   // ---------------------------------------------------------------- bus drivers

   task automatic send_word(input query_type w);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_func             <= w.func;
      req_box_x            <= w.box.x;
      req_box_y            <= w.box.y;
      req_box_w            <= w.box.w;
      req_box_h            <= w.box.h;
      req_pointer_x        <= w.px;
      req_pointer_y        <= w.py;
      req_button_held      <= w.held;
      req_button_went_down <= w.went;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (w.func) apply_query(w);
      else apply_tick();
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CSR_FRAME_TIME: frame_time_q = value[15:0];
         CSR_MOTION_ON:  motion_q     = value[0];
         CSR_HOVER_UP:   hover_up_q   = value[15:0];
         CSR_HOVER_DOWN: hover_down_q = value[15:0];
         CSR_PRESS_UP:   press_up_q   = value[15:0];
         CSR_PRESS_DOWN: press_down_q = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_config(input logic [15:0] ft, input logic mo,
                              input logic [15:0] hu, input logic [15:0] hd,
                              input logic [15:0] pu, input logic [15:0] pd);
      write_csr(CSR_FRAME_TIME, {16'd0, ft});
      write_csr(CSR_MOTION_ON,  {31'd0, mo});
      write_csr(CSR_HOVER_UP,   {16'd0, hu});
      write_csr(CSR_HOVER_DOWN, {16'd0, hd});
      write_csr(CSR_PRESS_UP,   {16'd0, pu});
      write_csr(CSR_PRESS_DOWN, {16'd0, pd});
   endtask

   task automatic pick_config(input int setting);
      case (setting)
         0: load_config(16'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
         1: load_config(16'hFFFF, 1'b1, 16'(FULL), 16'(FULL), 16'(FULL), 16'(FULL));
         2: load_config(16'($urandom), 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         3: load_config(16'($urandom), 1'b0, 16'($urandom_range(1, 6000)),
                        16'($urandom_range(1, 6000)), 16'($urandom_range(1, 6000)),
                        16'($urandom_range(1, 6000)));
         default: load_config(16'($urandom), 1'b1, 16'($urandom_range(1, 6000)),
                              16'($urandom_range(1, 6000)), 16'($urandom_range(1, 6000)),
                              16'($urandom_range(1, 6000)));
      endcase
   endtask

   // ---------------------------------------------------------------- result check

   always @(posedge clock) begin : watch_results
      levels_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_hover_level, rsp_press_level, rsp_hover_time};
         if (levels_due.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected result word: hover %0d press %0d time %0d",
                        got.hover, got.press, got.hover_time);
            fail_count++;
         end else begin
            want = levels_due.pop_front();
            if (got.hover !== want.hover || got.press !== want.press ||
                got.hover_time !== want.hover_time) begin
               if (fail_count < 10)
                  $display("result mismatch: hover %0d/%0d press %0d/%0d time %0d/%0d (exp/act)",
                           want.hover, got.hover, want.press, got.press,
                           want.hover_time, got.hover_time);
               fail_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_defaults();
      box_type a;
      a = make_box(-320, -160, 640, 320);
      send_word(make_query(a, 0, 0, 1'b1, 1'b1));
      send_word(tick_word());
      send_word(make_query(a, 100, 100, 1'b1, 1'b0));
      send_word(make_query(a, 320, 0, 1'b0, 1'b0));
      send_word(tick_word());
      send_word(tick_word());
      drain_results();
   endtask

   task automatic test_directed_cases();
      box_type a, edge_box;
      load_config(16'd1000, 1'b1, 16'd4000, 16'd3000, 16'd6000, 16'd2000);
      a = make_box(160, 320, 480, 160);
      send_word(make_query(a, 160, 320, 1'b1, 1'b1));
      send_word(make_query(a, 639, 479, 1'b1, 1'b0));
      send_word(make_query(make_box(167, 313, 487, 153), 300, 400, 1'b1, 1'b0));
      send_word(make_query(make_box(168, 320, 480, 160), 300, 400, 1'b0, 1'b0));
      send_word(make_query(a, 640, 400, 1'b0, 1'b0));
      send_word(make_query(a, 400, 480, 1'b0, 1'b0));
      send_word(tick_word());
      send_word(make_query(a, 300, 400, 1'b1, 1'b0));
      send_word(tick_word());
      send_word(make_query(a, 300, 400, 1'b1, 1'b0));
      send_word(make_query(make_box(0, 0, 0, 160), 0, 0, 1'b1, 1'b1));
      send_word(make_query(make_box(0, 0, 160, -16), 0, 0, 1'b1, 1'b1));
      edge_box = make_box(-32768, -32768, 32767, 32767);
      send_word(make_query(edge_box, -32768, -2, 1'b1, 1'b1));
      send_word(make_query(make_box(32767, 32767, -32768, -32768), 32767, 32767, 1'b1, 1'b1));
      send_word(make_query(edge_box, 32767, -1, 1'b0, 1'b0));
      // fill the table, then force an eviction
      for (int k = 0; k < SLOTS + 1; k++)
         send_word(make_query(make_box(1000 + 64 * k, -2000, 32, 32), 1000 + 64 * k, -2000,
                              k[0], 1'b0));
      send_word(tick_word());
      send_word(make_query(make_box(9000, 9000, 16, 16), 0, 0, 1'b0, 1'b0));
      drain_results();
   endtask

   task automatic test_motion_off();
      box_type a;
      load_config(16'd500, 1'b0, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
      a = make_box(2000, 2000, 320, 320);
      send_word(make_query(a, 2100, 2100, 1'b1, 1'b1));
      send_word(make_query(a, 2100, 2100, 1'b1, 1'b0));
      send_word(make_query(a, 2100, 2100, 1'b0, 1'b0));
      send_word(make_query(a, 1999, 2100, 1'b1, 1'b0));
      send_word(tick_word());
      send_word(make_query(a, 2319, 2319, 1'b1, 1'b0));
      send_word(tick_word());
      send_word(tick_word());
      send_word(make_query(a, 2100, 2100, 1'b0, 1'b1));
      drain_results();
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int first_setting);
      query_type    w;
      int           roll;
      logic [127:0] raw;
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      for (int seg = 0; seg < 3; seg++) begin
         drain_results();
         pick_config(first_setting + seg);
         fill_pool();
         repeat (150) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
               w = tick_word();
            end else if (roll < 40) begin
               raw = {$urandom, $urandom, $urandom, $urandom};
               w = raw[$bits(query_type)-1:0];
               w.func = 1'b1;
            end else begin
               w = random_query();
            end
            send_word(w);
         end
      end
      drain_results();
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      clear_predictor();
      req_idle_pct = 31;
      rsp_idle_pct = 75;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_cases();
      test_motion_off();
      test_random_traffic(31, 75, 0);
      test_random_traffic(75, 31, 3);
      test_random_traffic(0, 0, 6);
      if (fail_count == 0 && levels_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
